// ===== hdl/uvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV seam vertex splitter package
// Shared widths, codes and transaction types of the seam splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int VCOUNT_W         = 13;
  localparam int INDEX_W          = 12;
  localparam int COORD_W          = 32;
  localparam int EPOCH_W          = 8;

  typedef enum logic [0:0] {
    CMD_BEGIN  = 1'b0,
    CMD_CORNER = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                       command;
    logic [INDEX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0]  u_coord;
    logic signed [COORD_W-1:0]  v_coord;
  } corner_t;

  typedef struct packed {
    logic [INDEX_W-1:0] out_index;
    logic               duplicated;
    logic               first_use;
    status_t            status;
  } result_t;

  // One UV store entry: the mesh epoch that wrote it, then v over u.
  typedef struct packed {
    logic [EPOCH_W-1:0]   epoch;
    logic [2*COORD_W-1:0] uv;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/uvs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV seam splitter store
// Single write port, single read port RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_ram #(
  parameter int DEPTH = uvs_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = $bits(uvs_pkg::entry_t)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/uv_seam_vertex_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV seam vertex splitter
// Assigns split vertex indices to triangle corners whose UV differs at a seam.
// ----------------------------------------------------------------------------
// Usage:
//   The corner channel (corner_valid, corner_stall, corner) carries a begin
//   command or one triangle corner per transaction. The result channel
//   (result_valid, result_stall, result) returns one result per transaction,
//   in order. The cfg channel writes vertex_count; it is read by a begin.
//   A corner is taken every cycle while corner_stall is low. The UV store is
//   read at acceptance, the decision is made in the next cycle, and the
//   result register loads when the decision stage advances.
//   A write to the store is forwarded to a corner on the
//   same vertex that enters in the same cycle, so back-to-back corners keep
//   full rate; the single store port pair sets that figure.
//   Seen marks are epoch tags in the store. After reset, and after every
//   255th begin when the epoch wraps, a clearing pass writes all
//   MAX_VERTICES entries, one per cycle, with corner_stall high.
//   A stalled result holds in the output register; one more transaction can
//   then be held in the decision stage before corner_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_seam_vertex_splitter_top #(
  parameter int MAX_VERTICES = uvs_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [uvs_pkg::VCOUNT_W-1:0]    cfg_data,
  input  wire logic                            corner_valid,
  output logic                                 corner_stall,
  input  wire uvs_pkg::corner_t                corner,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output uvs_pkg::result_t                     result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (AW > uvs_pkg::INDEX_W) ? AW : uvs_pkg::INDEX_W;
  localparam int EW = uvs_pkg::EPOCH_W;
  localparam int DW = $bits(uvs_pkg::entry_t);

  logic [uvs_pkg::VCOUNT_W-1:0] vertex_count;
  logic [CW-1:0]                mesh_limit;
  logic [CW-1:0]                next_free;
  logic [EW-1:0]                cur_epoch;
  logic                         sweeping;
  logic [AW-1:0]                sweep_addr;

  logic                         s1_valid;
  uvs_pkg::corner_t             s1_item;
  logic                         fwd_hit;
  uvs_pkg::entry_t              fwd_entry;

  logic                         accept;
  logic                         s1_adv;
  logic                         wrap_begin;
  logic [XW-1:0]                in_ext;
  logic [AW-1:0]                in_addr;
  logic [XW-1:0]                s1_ext;
  logic [AW-1:0]                s1_addr;
  logic [DW-1:0]                ram_rd;
  uvs_pkg::entry_t              s1_entry;
  uvs_pkg::entry_t              new_entry;
  logic                         commit_write;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  uvs_pkg::entry_t              wr_entry;
  logic [31:0]                  limit_next;
  logic [31:0]                  fresh_ext;
  logic                         in_range;
  logic                         seen;
  logic                         full;
  uvs_pkg::result_t             res_next;

  assign cfg_ready = 1'b1;

  assign in_ext  = XW'(corner.vertex_index);
  assign in_addr = in_ext[AW-1:0];
  assign s1_ext  = XW'(s1_item.vertex_index);
  assign s1_addr = s1_ext[AW-1:0];

  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign wrap_begin = (s1_item.command == uvs_pkg::CMD_BEGIN) && (cur_epoch == {EW{1'b1}});
  // A wrapping begin must reach the clearing pass before any corner reads the store.
  assign corner_stall = sweeping || (s1_valid && (!s1_adv || wrap_begin));
  assign accept       = corner_valid && !corner_stall;

  assign s1_entry = fwd_hit ? fwd_entry : uvs_pkg::entry_t'(ram_rd);

  always_comb begin
    limit_next = 32'(vertex_count);
    if (limit_next > 32'(MAX_VERTICES)) begin
      limit_next = 32'(MAX_VERTICES);
    end
    fresh_ext = 32'(next_free);
    in_range  = 32'(s1_item.vertex_index) < 32'(mesh_limit);
    seen      = (s1_entry.epoch == cur_epoch);
    full      = 32'(next_free) >= 32'(MAX_VERTICES);
    new_entry.epoch = cur_epoch;
    new_entry.uv    = {s1_item.v_coord, s1_item.u_coord};
    commit_write    = 1'b0;

    res_next.out_index  = '0;
    res_next.duplicated = 1'b0;
    res_next.first_use  = 1'b0;
    res_next.status     = uvs_pkg::ST_OK;

    if (s1_item.command == uvs_pkg::CMD_CORNER) begin
      if (!in_range) begin
        res_next.status = uvs_pkg::ST_RANGE;
      end else if (!seen) begin
        commit_write       = s1_adv;
        res_next.out_index = s1_item.vertex_index;
        res_next.first_use = 1'b1;
      end else if (s1_entry.uv == new_entry.uv) begin
        res_next.out_index = s1_item.vertex_index;
      end else if (full) begin
        res_next.status = uvs_pkg::ST_FULL;
      end else begin
        res_next.out_index  = fresh_ext[uvs_pkg::INDEX_W-1:0];
        res_next.duplicated = 1'b1;
      end
    end
  end

  assign wr_en    = sweeping || commit_write;
  assign wr_addr  = sweeping ? sweep_addr : s1_addr;
  assign wr_entry = sweeping ? uvs_pkg::entry_t'('0) : new_entry;

  uvs_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd)
  );

  // Forwarding covers a write and a read of the same entry at one edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item   <= corner;
      fwd_entry <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      mesh_limit   <= '0;
      next_free    <= '0;
      cur_epoch    <= EW'(1);
      sweeping     <= 1'b1;
      sweep_addr   <= '0;
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end

      if (sweeping) begin
        sweep_addr <= sweep_addr + AW'(1);
        if (sweep_addr == AW'(MAX_VERTICES - 1)) begin
          sweeping <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= commit_write && (s1_addr == in_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_item.command == uvs_pkg::CMD_BEGIN) begin
          mesh_limit <= limit_next[CW-1:0];
          next_free  <= limit_next[CW-1:0];
          if (wrap_begin) begin
            cur_epoch  <= EW'(1);
            sweeping   <= 1'b1;
            sweep_addr <= '0;
          end else begin
            cur_epoch <= cur_epoch + EW'(1);
          end
        end else if (res_next.duplicated) begin
          next_free <= next_free + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire
